[design/lsc_pkg.sv]
`default_nettype none

package lsc_pkg;

  localparam int FEATURES_DEF      = 34;
  localparam int FEATURE_WIDTH_DEF = 16;
  localparam int ACC_W             = 40;
  localparam int LOG_W             = 48;
  localparam int ROM_FEATURES      = 34;
  localparam int TABLE_LAST        = 32;

  // Weight rows and biases, signed Q5.10.
  localparam logic signed [15:0] W0_ROM [ROM_FEATURES] = '{
    15950, 1554, -853, -538, -57, -360, -351, 17, -232, -292, -588, -751,
    -170, 428, -261, -497, -17, 465, -402, 588, -3122, -269, -1516, 632,
    91, 2176, -1034, -3011, 1490, -4033, -994, -3171, -264, -235
  };
  localparam logic signed [15:0] W1_ROM [ROM_FEATURES] = '{
    -15958, -1614, 653, 490, 165, 376, 356, 50, 253, 422, 509, 687,
    157, -530, 204, 440, 98, -756, 463, -612, 3166, 180, 1310, -369,
    -73, -2103, 1118, 3229, -1605, 4101, 724, 2985, 245, 353
  };
  localparam logic signed [15:0] BIAS0 = -16'sd1122;
  localparam logic signed [15:0] BIAS1 = 16'sd1100;

  // sigmoid(x) * 2^16 and ln(1 + exp(-x)) * 2^8 for x = 0, 0.5, ..., 16
  localparam logic [16:0] SIG_TAB [TABLE_LAST+1] = '{
    32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357, 64816,
    65097, 65269, 65374, 65438, 65476, 65500, 65514, 65523, 65528, 65531,
    65533, 65534, 65535, 65535, 65536, 65536, 65536, 65536, 65536, 65536,
    65536, 65536, 65536
  };
  localparam logic [7:0] SP_TAB [TABLE_LAST+1] = '{
    177, 121, 80, 52, 32, 20, 12, 8, 5, 3, 2, 1, 1, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic take;    // transfer: class-0 product of the incoming feature
    logic second;  // class-1 product of the held feature, advance index
    logic clear;   // drop both sums at end of vector
  } mac_ctrl_t;

  typedef struct packed {
    logic ld_logit0;
    logic ld_logit1;
    logic ld_diff;
    logic ld_lookup;
    logic ld_out;
  } post_ctrl_t;

  function automatic logic signed [15:0] rom_weight(input logic cls, input logic [7:0] idx);
    logic signed [15:0] w;
    w = '0;
    if (idx < 8'(ROM_FEATURES)) begin
      w = cls ? W1_ROM[idx[5:0]] : W0_ROM[idx[5:0]];
    end
    return w;
  endfunction

  function automatic logic signed [15:0] rom_bias(input logic cls);
    return cls ? BIAS1 : BIAS0;
  endfunction

endpackage

`default_nettype wire

[design/linear_softmax_classifier.sv]
`default_nettype none

// Channel   Direction  Handshake                        Payload
// feature   in         feature_valid_i / feature_stall_o feature_value_i
// result    out        result_valid_o / result_stall_i   logit, prob, logprob x2
//
// Each feature gives the class-0 product on transfer and the class-1
// product in the next cycle, both through the one shared multiplier.
// After the last feature of a vector, the states for two logit roundings on
// the shared rounding unit, difference, table lookup and output load give the result.
// Reset clears the index, both sums and the sequencer; no clearing pass.
// A result waiting under result_stall_i does not block features of the next
// vector; only the next result load waits for the output register.

module linear_softmax_classifier #(
  parameter int FEATURES      = lsc_pkg::FEATURES_DEF,
  parameter int FEATURE_WIDTH = lsc_pkg::FEATURE_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     feature_valid_i,
  output logic                          feature_stall_o,
  input  wire logic [FEATURE_WIDTH-1:0] feature_value_i,
  output logic                          result_valid_o,
  input  wire logic                     result_stall_i,
  output logic signed [15:0]            logit_class0_o,
  output logic signed [15:0]            logit_class1_o,
  output logic [15:0]                   prob_class0_o,
  output logic [15:0]                   prob_class1_o,
  output logic signed [15:0]            logprob_class0_o,
  output logic signed [15:0]            logprob_class1_o
);
  import lsc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MAC1   = 8'b0000_0010,
    ST_LOGIT0 = 8'b0000_0100,
    ST_LOGIT1 = 8'b0000_1000,
    ST_DIFF   = 8'b0001_0000,
    ST_LOOKUP = 8'b0010_0000,
    ST_RESULT = 8'b0100_0000,
    ST_SPARE  = 8'b1000_0000
  } state_e;

  state_e     state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       mac_last;
  mac_ctrl_t  mac_ctrl;
  post_ctrl_t post_ctrl;
  logic [ACC_W-1:0] acc0, acc1;

  always_comb begin
    state_d     = state_q;
    mac_ctrl    = '0;
    post_ctrl   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (feature_valid_i) begin
          mac_ctrl.take = 1'b1;
          state_d       = ST_MAC1;
        end
      end
      ST_MAC1: begin
        mac_ctrl.second = 1'b1;
        state_d         = mac_last ? ST_LOGIT0 : ST_IDLE;
      end
      ST_LOGIT0: begin
        post_ctrl.ld_logit0 = 1'b1;
        state_d             = ST_LOGIT1;
      end
      ST_LOGIT1: begin
        post_ctrl.ld_logit1 = 1'b1;
        mac_ctrl.clear      = 1'b1;
        state_d             = ST_DIFF;
      end
      ST_DIFF: begin
        post_ctrl.ld_diff = 1'b1;
        state_d           = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        post_ctrl.ld_lookup = 1'b1;
        state_d             = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register is free or being emptied
        if (!out_valid_q || !result_stall_i) begin
          post_ctrl.ld_out = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (post_ctrl.ld_out) begin
      out_valid_d = 1'b1;
    end else if (!result_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign feature_stall_o = (state_q != ST_IDLE);
  assign result_valid_o  = out_valid_q;

  lsc_mac #(
    .FEATURES      (FEATURES),
    .FEATURE_WIDTH (FEATURE_WIDTH)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .feature_i (feature_value_i),
    .last_o    (mac_last),
    .acc0_o    (acc0),
    .acc1_o    (acc1)
  );

  lsc_post #(
    .FEATURE_WIDTH (FEATURE_WIDTH)
  ) u_post (
    .clk_i            (clk_i),
    .ctrl_i           (post_ctrl),
    .acc0_i           (acc0),
    .acc1_i           (acc1),
    .logit_class0_o   (logit_class0_o),
    .logit_class1_o   (logit_class1_o),
    .prob_class0_o    (prob_class0_o),
    .prob_class1_o    (prob_class1_o),
    .logprob_class0_o (logprob_class0_o),
    .logprob_class1_o (logprob_class1_o)
  );

  a_last_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC1 && mac_last) |=> (state_q == ST_LOGIT0))
    else $error("last feature did not start the logit sequence");

  a_valid_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> $past(state_q == ST_RESULT))
    else $error("result raised outside the result state");

  a_prob_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((17'(prob_class0_o) + 17'(prob_class1_o) == 17'd65536) ||
                        (17'(prob_class0_o) + 17'(prob_class1_o) == 17'd65535)))
    else $error("probabilities do not sum to one");

  a_logprob_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((logprob_class0_o[15] || logprob_class0_o == 16'sd0) &&
                        (logprob_class1_o[15] || logprob_class1_o == 16'sd0)))
    else $error("positive log-probability");

endmodule

`default_nettype wire

[design/lsc_mac.sv]
`default_nettype none

module lsc_mac #(
  parameter int FEATURES      = 34,
  parameter int FEATURE_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lsc_pkg::mac_ctrl_t            ctrl_i,
  input  wire logic [FEATURE_WIDTH-1:0]      feature_i,
  output logic                               last_o,
  output logic [lsc_pkg::ACC_W-1:0]          acc0_o,
  output logic [lsc_pkg::ACC_W-1:0]          acc1_o
);
  import lsc_pkg::*;

  localparam int IDX_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int PROD_W = FEATURE_WIDTH + 17;
  localparam int EXT_W  = (PROD_W > ACC_W) ? PROD_W : ACC_W;

  logic [FEATURE_WIDTH-1:0]   x_q, x_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [ACC_W-1:0]           acc0_q, acc0_d, acc1_q, acc1_d;
  logic [7:0]                 rom_idx;
  logic signed [FEATURE_WIDTH:0] mul_a;
  logic signed [15:0]         mul_w;
  logic signed [PROD_W-1:0]   prod;
  logic signed [EXT_W-1:0]    prod_ext;
  logic [ACC_W-1:0]           addend;

  assign rom_idx  = 8'(idx_q);
  assign last_o   = (idx_q == IDX_W'(FEATURES - 1));

  // One multiplier serves both rows: class 0 on transfer, class 1 in the next cycle.
  assign mul_a    = $signed({1'b0, (ctrl_i.take ? feature_i : x_q)});
  assign mul_w    = rom_weight(!ctrl_i.take, rom_idx);
  assign prod     = mul_a * mul_w;
  assign prod_ext = EXT_W'(prod);
  assign addend   = prod_ext[ACC_W-1:0];

  always_comb begin
    x_d    = x_q;
    idx_d  = idx_q;
    acc0_d = acc0_q;
    acc1_d = acc1_q;
    if (ctrl_i.take) begin
      x_d    = feature_i;
      acc0_d = acc0_q + addend;
    end
    if (ctrl_i.second) begin
      acc1_d = acc1_q + addend;
      idx_d  = last_o ? '0 : idx_q + IDX_W'(1);
    end
    if (ctrl_i.clear) begin
      acc0_d = '0;
      acc1_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      acc0_q <= '0;
      acc1_q <= '0;
    end else begin
      idx_q  <= idx_d;
      acc0_q <= acc0_d;
      acc1_q <= acc1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  assign acc0_o = acc0_q;
  assign acc1_o = acc1_q;

endmodule

`default_nettype wire

[design/lsc_post.sv]
`default_nettype none

module lsc_post #(
  parameter int FEATURE_WIDTH = 16
) (
  input  wire logic                        clk_i,
  input  wire lsc_pkg::post_ctrl_t         ctrl_i,
  input  wire logic [lsc_pkg::ACC_W-1:0]   acc0_i,
  input  wire logic [lsc_pkg::ACC_W-1:0]   acc1_i,
  output logic signed [15:0]               logit_class0_o,
  output logic signed [15:0]               logit_class1_o,
  output logic [15:0]                      prob_class0_o,
  output logic [15:0]                      prob_class1_o,
  output logic signed [15:0]               logprob_class0_o,
  output logic signed [15:0]               logprob_class1_o
);
  import lsc_pkg::*;

  localparam int FB = FEATURE_WIDTH - 1;
  localparam int SH = FEATURE_WIDTH + 1;
  localparam logic signed [LOG_W-1:0] RND    = {{(LOG_W-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [LOG_W-1:0] SAT_HI = 32767;
  localparam logic signed [LOG_W-1:0] SAT_LO = -32768;
  localparam logic signed [17:0]      LP_MIN = -18'sd32768;

  // Shared rounding unit: sum + bias, round half up to Q8.8, saturate.
  logic [ACC_W-1:0]        acc_sel;
  logic signed [LOG_W-1:0] sum, shifted;
  logic signed [15:0]      logit_n;
  logic signed [15:0]      logit0_q, logit1_q;

  assign acc_sel = ctrl_i.ld_logit1 ? acc1_i : acc0_i;
  assign sum     = LOG_W'($signed(acc_sel))
                 + (LOG_W'(rom_bias(ctrl_i.ld_logit1)) <<< FB) + RND;
  assign shifted = sum >>> SH;

  always_comb begin
    priority if (shifted > SAT_HI) begin
      logit_n = 16'sh7FFF;
    end else if (shifted < SAT_LO) begin
      logit_n = 16'sh8000;
    end else begin
      logit_n = shifted[15:0];
    end
  end

  // Logit difference and its magnitude.
  logic signed [16:0] d_n, d_q;
  logic [16:0]        ad_n;
  logic [15:0]        ad_q;

  assign d_n  = 17'(logit0_q) - 17'(logit1_q);
  assign ad_n = d_n[16] ? 17'(-d_n) : 17'(d_n);

  // Interpolated table reads at steps of one half.
  logic [5:0]  i_lo, i_hi;
  logic [6:0]  frac;
  logic        big;
  logic [16:0] sig_lo, sig_hi, sig_delta, sig_n, sig_q;
  logic [23:0] sig_step;
  logic [7:0]  sp_lo, sp_hi, sp_delta, sp_n, sp_q;
  logic [14:0] sp_step;

  assign i_lo      = {1'b0, ad_q[11:7]};
  assign i_hi      = i_lo + 6'd1;
  assign frac      = ad_q[6:0];
  assign big       = |ad_q[15:12];
  assign sig_lo    = SIG_TAB[i_lo];
  assign sig_hi    = SIG_TAB[i_hi];
  assign sig_delta = sig_hi - sig_lo;
  assign sig_step  = (24'(sig_delta) * 24'(frac) + 24'd64) >> 7;
  assign sig_n     = big ? SIG_TAB[TABLE_LAST] : sig_lo + sig_step[16:0];
  assign sp_lo     = SP_TAB[i_lo];
  assign sp_hi     = SP_TAB[i_hi];
  assign sp_delta  = sp_lo - sp_hi;
  assign sp_step   = (15'(sp_delta) * 15'(frac) + 15'd64) >> 7;
  assign sp_n      = big ? SP_TAB[TABLE_LAST] : sp_lo - sp_step[7:0];

  // Final probabilities and log-probabilities.
  logic [16:0]        p0, p1;
  logic signed [17:0] dd, sp18, lp0, lp1;
  logic [15:0]        p0_sat, p1_sat;
  logic signed [15:0] lp0_sat, lp1_sat;

  assign p0   = d_q[16] ? 17'd65536 - sig_q : sig_q;
  assign p1   = 17'd65536 - p0;
  assign dd   = 18'(d_q);
  assign sp18 = $signed({10'd0, sp_q});
  assign lp0  = d_q[16] ? dd - sp18 : -sp18;
  assign lp1  = d_q[16] ? -sp18 : -dd - sp18;

  assign p0_sat  = p0[16] ? 16'hFFFF : p0[15:0];
  assign p1_sat  = p1[16] ? 16'hFFFF : p1[15:0];
  assign lp0_sat = (lp0 < LP_MIN) ? 16'sh8000 : lp0[15:0];
  assign lp1_sat = (lp1 < LP_MIN) ? 16'sh8000 : lp1[15:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_logit0) begin
      logit0_q <= logit_n;
    end
    if (ctrl_i.ld_logit1) begin
      logit1_q <= logit_n;
    end
    if (ctrl_i.ld_diff) begin
      d_q  <= d_n;
      ad_q <= ad_n[15:0];
    end
    if (ctrl_i.ld_lookup) begin
      sig_q <= sig_n;
      sp_q  <= sp_n;
    end
    if (ctrl_i.ld_out) begin
      logit_class0_o   <= logit0_q;
      logit_class1_o   <= logit1_q;
      prob_class0_o    <= p0_sat;
      prob_class1_o    <= p1_sat;
      logprob_class0_o <= lp0_sat;
      logprob_class1_o <= lp1_sat;
    end
  end

endmodule

`default_nettype wire
